@@ sv/lwct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the cache tag store.
// No dependencies; every other file of the block refers to it.
package lwct_pkg;

	// Default geometry handed to the top level parameters.
	localparam int ENTRIES_DEF   = 16;
	localparam int ADDR_BITS_DEF = 32;

	// Capacity register.
	localparam int             CFG_BITS  = 5;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

	// Access codes.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_STORE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} dp_cmd_t;

endpackage

@@ sv/lwct_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the cache tag store: access requests, results
// and capacity writes. Depends on lwct_pkg.
interface lwct_req_if #(
	parameter int ADDR_BITS = lwct_pkg::ADDR_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [ADDR_BITS-1:0] addr;

	modport source (output valid, output action, output addr, input ready);
	modport sink   (input valid, input action, input addr, output ready);
endinterface

interface lwct_rsp_if #(
	parameter int ADDR_BITS = lwct_pkg::ADDR_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 fetch_needed;
	logic                 writeback_valid;
	logic [ADDR_BITS-1:0] writeback_addr;
	logic                 store_miss_error;

	modport source (output valid, output hit, output fetch_needed, output writeback_valid,
		output writeback_addr, output store_miss_error, input ready);
	modport sink   (input valid, input hit, input fetch_needed, input writeback_valid,
		input writeback_addr, input store_miss_error, output ready);
endinterface

interface lwct_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lwct_pkg::CFG_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/lwct_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the cache tag store: request intake, lookup, commit and
// the result valid flag. Depends on lwct_pkg.
module lwct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lwct_pkg::dp_cmd_t cmd
);

	lwct_pkg::ctrl_state_t state_q, state_d;
	logic                  rsp_valid_q;
	logic                  can_commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lwct_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign can_commit = !rsp_valid_q || rsp_ready;
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			lwct_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = lwct_pkg::ST_LOOKUP;
				end
			end
			lwct_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = lwct_pkg::ST_COMMIT;
			end
			lwct_pkg::ST_COMMIT: begin
				// The next request may enter in the same cycle the result is written.
				if (can_commit) begin
					cmd.commit = 1'b1;
					req_ready  = 1'b1;
					if (req_valid) begin
						cmd.capture = 1'b1;
						state_d     = lwct_pkg::ST_LOOKUP;
					end else begin
						state_d = lwct_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = lwct_pkg::ST_IDLE;
			end
		endcase
	end

	a_lookup_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lwct_pkg::ST_LOOKUP |=> state_q == lwct_pkg::ST_COMMIT)
		else $error("lookup not followed by commit");

	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("commit did not raise result valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten before it was taken");

endmodule

@@ sv/lwct_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the cache tag store: tag, dirty and recency registers, the
// parallel compare, victim choice, fill and the result register. Depends on lwct_pkg.
module lwct_dp #(
	parameter int ENTRIES   = lwct_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = lwct_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lwct_pkg::dp_cmd_t             cmd,
	input  logic                          req_action,
	input  logic [ADDR_BITS-1:0]          req_addr,
	input  logic                          cfg_wr,
	input  logic [lwct_pkg::CFG_BITS-1:0] cfg_data,
	output logic                          hit,
	output logic                          fetch_needed,
	output logic                          writeback_valid,
	output logic [ADDR_BITS-1:0]          writeback_addr,
	output logic                          store_miss_error
);

	localparam int RW   = $clog2(ENTRIES);
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > lwct_pkg::CFG_BITS) ? CW : lwct_pkg::CFG_BITS;
	localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

	logic [lwct_pkg::CFG_BITS-1:0] cap_cfg_q;
	logic                          action_q;
	logic [ADDR_BITS-1:0]          addr_q;
	logic [ENTRIES-1:0]            valid_q, dirty_q;
	logic [RW-1:0]                 rank_q [ENTRIES];
	logic [ADDR_BITS-1:0]          tag_q  [ENTRIES];
	logic [CW-1:0]                 occ_q;

	logic [ENTRIES-1:0] hit_vec_s1, victim_vec_s1;
	logic               full_s1;

	logic [CMPW-1:0]    cfg_ext, cap, occ_ext;
	logic               full;
	logic [ENTRIES-1:0] hit_vec, victim_vec;

	logic               hit_any, is_store, load_hit, load_miss, evict, victim_dirty;
	logic [RW-1:0]      old_rank;
	logic [ADDR_BITS-1:0] victim_tag;
	logic [ENTRIES-1:0] evict_vec, valid_kept, free_vec, fill_vec;
	logic [ENTRIES-1:0] valid_d, dirty_d;
	logic [RW-1:0]      rank_d [ENTRIES];
	logic [CW-1:0]      occ_d;

	// Effective capacity: zero acts as one, large values clamp to the entry count.
	assign cfg_ext = CMPW'(cap_cfg_q);
	assign occ_ext = CMPW'(occ_q);
	always_comb begin
		if (cfg_ext == '0) begin
			cap = CMPW'(1);
		end else if (cfg_ext > ENTRIES_C) begin
			cap = ENTRIES_C;
		end else begin
			cap = cfg_ext;
		end
	end
	assign full = (occ_ext >= cap) && (occ_q != '0);

	// Lookup: every entry compares at once; the victim is the valid entry
	// holding the oldest rank, which is the occupancy minus one.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i]    = valid_q[i] && (tag_q[i] == addr_q);
			victim_vec[i] = valid_q[i] && (CW'(rank_q[i]) == occ_q - CW'(1));
		end
	end

	// Commit-side decode.
	assign hit_any   = |hit_vec_s1;
	assign is_store  = (action_q == lwct_pkg::ACT_STORE);
	assign load_hit  = !is_store && hit_any;
	assign load_miss = !is_store && !hit_any;
	assign evict     = load_miss && full_s1;
	assign evict_vec = evict ? victim_vec_s1 : '0;

	always_comb begin
		old_rank     = '0;
		victim_tag   = '0;
		victim_dirty = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_vec_s1[i]) begin
				old_rank = old_rank | rank_q[i];
			end
			if (victim_vec_s1[i]) begin
				victim_tag   = victim_tag | tag_q[i];
				victim_dirty = victim_dirty | dirty_q[i];
			end
		end
	end

	// Fill goes to the lowest free slot once the victim is gone.
	assign valid_kept = valid_q & ~evict_vec;
	assign free_vec   = ~valid_kept;
	assign fill_vec   = free_vec & (~free_vec + ENTRIES'(1));

	always_comb begin
		valid_d = valid_q;
		dirty_d = dirty_q;
		occ_d   = occ_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (load_miss) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_kept[i]) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end else begin
					rank_d[i] = '0;
				end
			end
			valid_d = valid_kept | fill_vec;
			dirty_d = dirty_q & ~evict_vec & ~fill_vec;
			occ_d   = occ_q - CW'(evict) + CW'(|fill_vec);
		end else if (load_hit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (hit_vec_s1[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < old_rank)) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end
			end
		end else if (hit_any) begin
			dirty_d = dirty_q | hit_vec_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q     <= lwct_pkg::CFG_RESET;
			valid_q       <= '0;
			dirty_q       <= '0;
			occ_q         <= '0;
			hit_vec_s1    <= '0;
			victim_vec_s1 <= '0;
			full_s1       <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				cap_cfg_q <= cfg_data;
			end
			if (cmd.lookup) begin
				hit_vec_s1    <= hit_vec;
				victim_vec_s1 <= victim_vec;
				full_s1       <= full;
			end
			if (cmd.commit) begin
				valid_q <= valid_d;
				dirty_q <= dirty_d;
				occ_q   <= occ_d;
				for (int i = 0; i < ENTRIES; i++) begin
					rank_q[i] <= rank_d[i];
				end
			end
		end
	end

	// Payload registers: request capture, tags and the result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= req_action;
			addr_q   <= req_addr;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.commit && load_miss && fill_vec[i]) begin
				tag_q[i] <= addr_q;
			end
		end
		if (cmd.commit) begin
			hit              <= hit_any;
			fetch_needed     <= load_miss;
			writeback_valid  <= evict && victim_dirty;
			writeback_addr   <= (evict && victim_dirty) ? victim_tag : '0;
			store_miss_error <= is_store && !hit_any;
		end
	end

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy count disagrees with valid bits");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec_s1))
		else $error("address matched more than one entry");

	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && evict) |-> $onehot(victim_vec_s1))
		else $error("eviction without exactly one victim");

endmodule

@@ sv/lru_writeback_cache_tags.sv @@
`timescale 1ns / 1ps
// Top level of the fully associative write-back cache tag store.
// Depends on lwct_pkg, the channel interfaces, lwct_ctrl and lwct_dp.
//
//   Channel  Direction  Carries
//   req      in         action (load or store), block address
//   rsp      out        hit, fetch_needed, writeback_valid/addr, store_miss_error
//   cfg      in         entries_in_use, the capacity before eviction
//
// Each request passes a lookup step, comparing the address with all tags in
// parallel and marking the victim, then a commit step that may evict it, updates
// recency and writes the result. The next request is taken in the commit step,
// so while results are taken promptly a new one enters as the last commits. A
// result waiting in the output register holds the commit until it is taken; one
// request can be captured and looked up behind it. Reset clears all entries at
// once and sets the capacity to sixteen; the capacity port is always ready.
module lru_writeback_cache_tags #(
	parameter int ENTRIES   = lwct_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = lwct_pkg::ADDR_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	lwct_req_if.sink   req,
	lwct_rsp_if.source rsp,
	lwct_cfg_if.sink   cfg
);

	lwct_pkg::dp_cmd_t cmd;
	logic              cfg_wr;

	// The user must rewrite capacity only with no request in flight; not checked.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	// The controller owns the handshakes and the sequencing of each request.
	lwct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds tags, dirty bits, recency ranks and the result register.
	lwct_dp #(
		.ENTRIES   (ENTRIES),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.req_action       (req.action),
		.req_addr         (req.addr),
		.cfg_wr           (cfg_wr),
		.cfg_data         (cfg.data),
		.hit              (rsp.hit),
		.fetch_needed     (rsp.fetch_needed),
		.writeback_valid  (rsp.writeback_valid),
		.writeback_addr   (rsp.writeback_addr),
		.store_miss_error (rsp.store_miss_error)
	);

endmodule

@@ sim/lwct_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the cache tag store: keeps its own copy of tags, dirty bits,
// load order and capacity, predicts every result and checks it. Depends on lwct_pkg.
module lwct_scoreboard #(
	parameter int ENTRIES   = lwct_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = lwct_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic                          req_action,
	input  logic [ADDR_BITS-1:0]          req_addr,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic                          rsp_hit,
	input  logic                          rsp_fetch_needed,
	input  logic                          rsp_writeback_valid,
	input  logic [ADDR_BITS-1:0]          rsp_writeback_addr,
	input  logic                          rsp_store_miss_error,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [lwct_pkg::CFG_BITS-1:0] cfg_data,
	output int                            mismatches,
	output int                            outstanding,
	output int                            results_seen,
	output int                            writebacks_seen,
	output int                            store_misses_seen
);

	typedef struct packed {
		logic                 hit;
		logic                 fetch_needed;
		logic                 writeback_valid;
		logic [ADDR_BITS-1:0] writeback_addr;
		logic                 store_miss_error;
	} access_result_t;

	logic                          line_valid [ENTRIES];
	logic [ADDR_BITS-1:0]          line_tag   [ENTRIES];
	logic                          line_dirty [ENTRIES];
	int                            load_age   [ENTRIES];
	int                            lines_held;
	logic [lwct_pkg::CFG_BITS-1:0] capacity_reg;
	access_result_t                pending_results [$];
	int                            bad_count, result_count, wb_count, miss_count;

	// Applies one access to the mirrored state and returns the result it must give.
	task automatic apply_access(input logic act, input logic [ADDR_BITS-1:0] a,
		output access_result_t r);
		int slot, victim, old_age, limit;
		r = '0;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (line_valid[i] && line_tag[i] == a && slot < 0) slot = i;
		if (act == lwct_pkg::ACT_STORE) begin
			if (slot >= 0) begin
				r.hit = 1'b1;
				line_dirty[slot] = 1'b1;
			end else begin
				r.store_miss_error = 1'b1;
			end
		end else if (slot >= 0) begin
			r.hit = 1'b1;
			old_age = load_age[slot];
			for (int i = 0; i < ENTRIES; i++)
				if (line_valid[i] && load_age[i] < old_age) load_age[i]++;
			load_age[slot] = 0;
		end else begin
			r.fetch_needed = 1'b1;
			limit = (capacity_reg == 0) ? 1 : ((capacity_reg > ENTRIES) ? ENTRIES : capacity_reg);
			if (lines_held >= limit && lines_held > 0) begin
				victim = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (line_valid[i] && (victim < 0 || load_age[i] > load_age[victim]))
						victim = i;
				if (line_dirty[victim]) begin
					r.writeback_valid = 1'b1;
					r.writeback_addr  = line_tag[victim];
				end
				line_valid[victim] = 1'b0;
				line_dirty[victim] = 1'b0;
				load_age[victim]   = 0;
				lines_held--;
			end
			slot = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (!line_valid[i] && slot < 0) slot = i;
			for (int i = 0; i < ENTRIES; i++)
				if (line_valid[i]) load_age[i]++;
			line_valid[slot] = 1'b1;
			line_tag[slot]   = a;
			line_dirty[slot] = 1'b0;
			load_age[slot]   = 0;
			lines_held++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t predicted, seen;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				line_valid[i] = 1'b0;
				line_tag[i]   = '0;
				line_dirty[i] = 1'b0;
				load_age[i]   = 0;
			end
			lines_held   = 0;
			capacity_reg = lwct_pkg::CFG_RESET;
			pending_results.delete();
			bad_count    = 0;
			result_count = 0;
			wb_count     = 0;
			miss_count   = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) capacity_reg = cfg_data;
			if (req_valid && req_ready) begin
				apply_access(req_action, req_addr, predicted);
				pending_results.push_back(predicted);
			end
			if (rsp_valid && rsp_ready) begin
				seen = '{hit: rsp_hit, fetch_needed: rsp_fetch_needed,
					writeback_valid: rsp_writeback_valid,
					writeback_addr: rsp_writeback_addr,
					store_miss_error: rsp_store_miss_error};
				result_count++;
				if (rsp_writeback_valid === 1'b1) wb_count++;
				if (rsp_store_miss_error === 1'b1) miss_count++;
				if (pending_results.size() == 0) begin
					bad_count++;
					$display("%0t: expected none, got hit=%b fetch=%b wb=%b/%h err=%b",
						$time, seen.hit, seen.fetch_needed, seen.writeback_valid,
						seen.writeback_addr, seen.store_miss_error);
				end else begin
					predicted = pending_results.pop_front();
					if (seen !== predicted) begin
						bad_count++;
						$display(
							"%0t: exp h=%b f=%b wb=%b/%h e=%b got h=%b f=%b wb=%b/%h e=%b",
							$time, predicted.hit, predicted.fetch_needed,
							predicted.writeback_valid, predicted.writeback_addr,
							predicted.store_miss_error, seen.hit, seen.fetch_needed,
							seen.writeback_valid, seen.writeback_addr,
							seen.store_miss_error);
					end
				end
			end
			outstanding <= pending_results.size();
		end
	end

	always @(posedge clk) begin
		mismatches        <= bad_count;
		results_seen      <= result_count;
		writebacks_seen   <= wb_count;
		store_misses_seen <= miss_count;
	end

endmodule

@@ sim/lru_writeback_cache_tags_tb.sv @@
`timescale 1ns / 1ps
// Top of the testbench for the cache tag store: clock, reset, request and
// capacity stimulus, result flow control and the verdict. Depends on lwct_pkg,
// the channel interfaces, lru_writeback_cache_tags and lwct_scoreboard.
module lru_writeback_cache_tags_tb;

	localparam int ENTRIES       = lwct_pkg::ENTRIES_DEF;
	localparam int ADDR_BITS     = lwct_pkg::ADDR_BITS_DEF;
	localparam int SETTLE_CYCLES = 6;     // slack after the last result comes back
	localparam int LONG_HOLD     = 150;   // result stall that backs the block up
	localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
	localparam int PHASE_ITEMS   = 140;

	logic clk;
	logic arst_n;

	lwct_req_if #(.ADDR_BITS(ADDR_BITS)) req_ch ();
	lwct_rsp_if #(.ADDR_BITS(ADDR_BITS)) rsp_ch ();
	lwct_cfg_if                          cfg_ch ();

	int mismatches, outstanding, results_seen, writebacks_seen, store_misses_seen;

	// Knobs shared between the request side and the result side. The request
	// side sets them per phase; the result side reads them every cycle.
	bit quiet;            // no idling at all, used for the closing phase
	int send_idle_pct;    // chance of a gap before a request
	int take_idle_pct;    // chance of a stall on the result side
	bit long_hold_req;    // asks the result side for one long stall
	int accesses_sent;
	int settings_used;
	int idle_cycles;

	lru_writeback_cache_tags #(
		.ENTRIES  (ENTRIES),
		.ADDR_BITS(ADDR_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	lwct_scoreboard #(
		.ENTRIES  (ENTRIES),
		.ADDR_BITS(ADDR_BITS)
	) u_scoreboard (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req_valid           (req_ch.valid),
		.req_ready           (req_ch.ready),
		.req_action          (req_ch.action),
		.req_addr            (req_ch.addr),
		.rsp_valid           (rsp_ch.valid),
		.rsp_ready           (rsp_ch.ready),
		.rsp_hit             (rsp_ch.hit),
		.rsp_fetch_needed    (rsp_ch.fetch_needed),
		.rsp_writeback_valid (rsp_ch.writeback_valid),
		.rsp_writeback_addr  (rsp_ch.writeback_addr),
		.rsp_store_miss_error(rsp_ch.store_miss_error),
		.cfg_valid           (cfg_ch.valid),
		.cfg_ready           (cfg_ch.ready),
		.cfg_data            (cfg_ch.data),
		.mismatches          (mismatches),
		.outstanding         (outstanding),
		.results_seen        (results_seen),
		.writebacks_seen     (writebacks_seen),
		.store_misses_seen   (store_misses_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The watchdog only counts cycles in which no channel moves anything, so a
	// slow but live run never trips it, while a hung handshake does.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no request, result or write moved for %0d cycles.", IDLE_LIMIT);
			$display("[lru_writeback_cache_tags] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side. It alternates runs of ready with stalls of random length.
	// Once the request side asks for it and a request is on offer, it holds
	// ready low for a long count of its own so that the block fills up and
	// pushes back on requests.
	initial begin
		int stall_left, run_left;
		bit hold_done;
		stall_left   = 0;
		run_left     = 0;
		hold_done    = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done && req_ch.valid === 1'b1) begin
				hold_done  = 1'b1;
				stall_left = LONG_HOLD;
				run_left   = 0;
			end else if (stall_left == 0 && run_left == 0) begin
				if (!quiet && $urandom_range(0, 99) < take_idle_pct)
					stall_left = $urandom_range(1, 18);
				else
					run_left = $urandom_range(1, 40);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (run_left > 0) run_left--;
			end
		end
	end

	// Offers one request and returns at the edge where it is taken. Valid stays
	// high on return so that back-to-back requests need no extra assignment.
	task automatic send_access(input logic act, input logic [ADDR_BITS-1:0] a);
		int gap;
		if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 18);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.addr   <= a;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		accesses_sent++;
	endtask

	// Drops valid and waits until every predicted result has come back, then a
	// few more cycles so the block is fully quiet.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Capacity writes happen only with the block idle.
	task automatic write_capacity(input logic [lwct_pkg::CFG_BITS-1:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// One random phase at a given capacity. Addresses mostly come from a small
	// working set a little larger than the capacity, so loads hit, stores find
	// their line, and misses evict lines that were written; the rest are fresh
	// addresses that miss, including stores to absent lines.
	task automatic run_phase(input logic [lwct_pkg::CFG_BITS-1:0] cap_value, input int count);
		logic [ADDR_BITS-1:0] working_set [$];
		logic [ADDR_BITS-1:0] a;
		logic                 act;
		int                   set_size;
		write_capacity(cap_value);
		set_size = ((cap_value > ENTRIES) ? ENTRIES : cap_value) + $urandom_range(1, 4);
		for (int i = 0; i < set_size; i++) begin
			case ($urandom_range(0, 15))
				0:       working_set.push_back('0);
				1:       working_set.push_back('1);
				default: working_set.push_back(ADDR_BITS'($urandom));
			endcase
		end
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 85)
				a = working_set[$urandom_range(0, working_set.size() - 1)];
			else
				a = ADDR_BITS'($urandom);
			act = ($urandom_range(0, 99) < 35) ? lwct_pkg::ACT_STORE : lwct_pkg::ACT_LOAD;
			send_access(act, a);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = lwct_pkg::ACT_LOAD;
		req_ch.addr   = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		quiet         = 1'b0;
		send_idle_pct = 20;
		take_idle_pct = 20;
		long_hold_req = 1'b0;
		accesses_sent = 0;
		settings_used = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity: misses at both ends of the
		// address range, a store that marks a line dirty, a store to a line
		// that is not there, and load hits that refresh the order.
		send_access(lwct_pkg::ACT_LOAD,  '0);
		send_access(lwct_pkg::ACT_LOAD,  '1);
		send_access(lwct_pkg::ACT_STORE, '0);
		send_access(lwct_pkg::ACT_STORE, 32'hA5A5_5A5A);
		send_access(lwct_pkg::ACT_LOAD,  '0);
		send_access(lwct_pkg::ACT_LOAD,  '1);
		send_access(lwct_pkg::ACT_STORE, '1);

		// A capacity of zero behaves as one, and it now sits below the two lines
		// already held: every load miss evicts the oldest loaded line, and both
		// of them are dirty, so write-backs follow.
		write_capacity(5'd0);
		send_access(lwct_pkg::ACT_LOAD,  32'h0000_0001);
		send_access(lwct_pkg::ACT_LOAD,  '0);
		send_access(lwct_pkg::ACT_LOAD,  '0);
		send_access(lwct_pkg::ACT_STORE, 32'h0000_0001);
		send_access(lwct_pkg::ACT_STORE, 32'h0000_0002);
		send_access(lwct_pkg::ACT_LOAD,  32'h0000_0003);

		// A value above the entry count behaves as the full store.
		run_phase(5'd31, PHASE_ITEMS);

		// Lowering the capacity with a full store exercises the shrinking path.
		run_phase(5'd5, PHASE_ITEMS);

		// Back-pressure phase: the sender never pauses while the result side
		// holds off for a long stretch.
		send_idle_pct = 0;
		long_hold_req = 1'b1;
		run_phase(5'd16, PHASE_ITEMS);

		send_idle_pct = 35;
		take_idle_pct = 35;
		run_phase(5'd2, PHASE_ITEMS);

		send_idle_pct = 0;
		take_idle_pct = 0;
		run_phase(5'd1, PHASE_ITEMS);

		send_idle_pct = 20;
		take_idle_pct = 20;
		run_phase(5'd7, PHASE_ITEMS);

		// Closing phase runs at full rate with no idling on either side.
		quiet = 1'b1;
		run_phase(5'd16, PHASE_ITEMS);

		drain();
		$display(
			"Covered %0d accesses over %0d capacity writes, incl. zero, one, full, oversize.",
			accesses_sent, settings_used);
		$display("Checked %0d results, %0d write-backs, %0d store misses, one long stall.",
			results_seen, writebacks_seen, store_misses_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[lru_writeback_cache_tags] OK");
		end else begin
			$display("[lru_writeback_cache_tags] ERROR");
		end
		$finish;
	end

endmodule
